/* rtl/cbft_pkg.sv */
// ----------------------------------------------------------------------------
// cbft_pkg
// Shared constants for the CAN base frame transmitter: command and status
// codes and the frame layout figures.
// ----------------------------------------------------------------------------
`default_nettype none

package cbft_pkg;

  // command codes carried in the mode field
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // status codes reported with every result word
  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_SENDING    = 3'd1;
  localparam logic [2:0] ST_DONE_ACK   = 3'd2;
  localparam logic [2:0] ST_DONE_NOACK = 3'd3;
  localparam logic [2:0] ST_ARB_LOST   = 3'd4;
  localparam logic [2:0] ST_REJECTED   = 3'd5;
  localparam logic [2:0] ST_BUSY       = 3'd6;

  // frame layout, in frame bits (stuff bits not counted)
  localparam int unsigned POS_W      = 7;
  localparam logic [6:0]  DATA_START = 7'd19;
  localparam logic [6:0]  CRC_BITS   = 7'd15;
  localparam logic [6:0]  ACK_CHECK  = 7'd17;  // readback of the ACK slot
  localparam logic [6:0]  FRAME_TAIL = 7'd25;  // CRC, delimiters, ACK, EOF

  localparam logic [14:0] CRC_POLY  = 15'h4599;
  localparam logic [2:0]  STUFF_RUN = 3'd5;
  localparam logic [3:0]  MAX_BYTES = 4'd8;

endpackage

`default_nettype wire

/* rtl/cbft_frame_bit.sv */
// ----------------------------------------------------------------------------
// cbft_frame_bit
// Selects the unstuffed frame bit at a given position from the latched
// identifier, DLC, data and running CRC, and flags the stuffing and CRC zones.
// ----------------------------------------------------------------------------
`default_nettype none

module cbft_frame_bit (
  input  wire logic [6:0]  bit_position,
  input  wire logic [10:0] id_store,
  input  wire logic [3:0]  length_store,
  input  wire logic [63:0] payload_store,
  input  wire logic [14:0] crc_register,
  output logic [6:0]       crc_start,
  output logic             frame_bit,
  output logic             in_crc_feed,
  output logic             in_stuff_zone
);
  import cbft_pkg::*;

  logic [6:0] data_off;
  logic [6:0] crc_off;
  logic [3:0] id_idx;
  logic [1:0] dlc_idx;
  logic [5:0] pay_idx;
  logic [3:0] crc_idx;

  // length_store never exceeds eight bytes once loaded
  assign crc_start     = DATA_START + {length_store, 3'b000};
  assign in_crc_feed   = bit_position < crc_start;
  assign in_stuff_zone = bit_position < (crc_start + CRC_BITS);

  assign data_off = bit_position - DATA_START;
  assign crc_off  = bit_position - crc_start;
  assign id_idx   = 4'(7'd11 - bit_position);
  assign dlc_idx  = 2'(7'd18 - bit_position);
  assign pay_idx  = 6'd63 - data_off[5:0];
  assign crc_idx  = 4'd14 - crc_off[3:0];

  // field select: SOF, ID, RTR/IDE/r0, DLC, data, CRC, recessive tail
  always_comb begin
    if (bit_position == 7'd0) begin
      frame_bit = 1'b0;
    end else if (bit_position <= 7'd11) begin
      frame_bit = id_store[id_idx];
    end else if (bit_position <= 7'd14) begin
      frame_bit = 1'b0;
    end else if (bit_position < DATA_START) begin
      frame_bit = length_store[dlc_idx];
    end else if (in_crc_feed) begin
      frame_bit = payload_store[pay_idx];
    end else if (in_stuff_zone) begin
      frame_bit = crc_register[crc_idx];
    end else begin
      frame_bit = 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/can_base_frame_transmitter_unit.sv */
// ----------------------------------------------------------------------------
// can_base_frame_transmitter_unit
// CAN 2.0A base data frame transmitter, one bus bit per tick word.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): a load word (mode 0) latches identifier,
// DLC and data and starts a frame when idle with a DLC of at most 8; a tick
// word (mode 1) advances one bit time, carrying the bus level read back for
// the bit driven on the previous tick. Output channel (out_valid/out_ready):
// exactly one result word per input word: the level to drive, a status code
// and a frame_done flag. The result of a word is registered and shown from
// the edge after it is accepted. Throughput is one word per cycle; the frame
// state and the result register are updated in the same edge, with the bit
// select, the stuffing counter and the CRC-15 step in between.
// If the receiver stalls, the result register holds and in_ready stays low
// until it is taken; a result leaving and a new word entering can share one
// edge. Stuff bits are inserted from SOF through the last CRC bit; a stuff
// bit starts the next run. A recessive bit read back dominant (outside the
// ACK slot) aborts the frame.
// Reset clears the output register and returns the transmitter to idle,
// driving recessive.
// ----------------------------------------------------------------------------
`default_nettype none

module can_base_frame_transmitter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        mode,
  input  wire logic [10:0] frame_id,
  input  wire logic [3:0]  data_length,
  input  wire logic [63:0] payload,
  input  wire logic        rx_level,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             tx_level,
  output logic [2:0]       status,
  output logic             frame_done
);
  import cbft_pkg::*;

  typedef enum logic {PH_IDLE, PH_SEND} phase_t;

  phase_t      phase, phase_next;
  logic [6:0]  bit_position, bit_position_next;
  logic [10:0] id_store, id_store_next;
  logic [3:0]  length_store, length_store_next;
  logic [63:0] payload_store, payload_store_next;
  logic [14:0] crc_register, crc_register_next;
  logic [2:0]  run_length, run_length_next;
  logic        last_bit, last_bit_next;
  logic        stuff_pending, stuff_pending_next;
  logic        last_sent, last_sent_next;
  logic        ack_flag, ack_flag_next;

  logic        res_tx;
  logic [2:0]  res_status;
  logic        res_done;
  logic        accept;

  logic [6:0]  crc_start;
  logic        fbit;
  logic        in_crc_feed;
  logic        in_stuff_zone;
  logic [14:0] crc_shift;

  cbft_frame_bit u_frame_bit (
    .bit_position  (bit_position),
    .id_store      (id_store),
    .length_store  (length_store),
    .payload_store (payload_store),
    .crc_register  (crc_register),
    .crc_start     (crc_start),
    .frame_bit     (fbit),
    .in_crc_feed   (in_crc_feed),
    .in_stuff_zone (in_stuff_zone)
  );

  // take a word whenever the result register is free or being emptied
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // one CRC-15 step on the frame bit
  assign crc_shift = {crc_register[13:0], 1'b0} ^
                     ((crc_register[14] ^ fbit) ? CRC_POLY : 15'd0);

  // next frame state and result word
  always_comb begin
    phase_next         = phase;
    bit_position_next  = bit_position;
    id_store_next      = id_store;
    length_store_next  = length_store;
    payload_store_next = payload_store;
    crc_register_next  = crc_register;
    run_length_next    = run_length;
    last_bit_next      = last_bit;
    stuff_pending_next = stuff_pending;
    last_sent_next     = last_sent;
    ack_flag_next      = ack_flag;
    res_tx             = 1'b1;
    res_status         = ST_IDLE;
    res_done           = 1'b0;

    if (mode == MODE_LOAD) begin
      if (phase == PH_SEND) begin
        res_tx     = last_sent;
        res_status = ST_BUSY;
      end else if (data_length > MAX_BYTES) begin
        res_status = ST_REJECTED;
        res_done   = 1'b1;
      end else begin
        phase_next         = PH_SEND;
        id_store_next      = frame_id;
        length_store_next  = data_length;
        payload_store_next = payload;
        bit_position_next  = 7'd0;
        crc_register_next  = 15'd0;
        run_length_next    = 3'd0;
        last_bit_next      = 1'b0;
        stuff_pending_next = 1'b0;
        last_sent_next     = 1'b1;
        ack_flag_next      = 1'b0;
        res_status         = ST_SENDING;
      end
    end else if (phase == PH_SEND) begin
      if (bit_position != 7'd0 && bit_position == crc_start + ACK_CHECK) begin
        // ACK slot readback: dominant means acknowledged
        if (!rx_level) begin
          ack_flag_next = 1'b1;
        end
      end

      if (bit_position != 7'd0 && bit_position != crc_start + ACK_CHECK &&
          last_sent && !rx_level) begin
        // arbitration lost or bus error on a recessive bit
        phase_next     = PH_IDLE;
        last_sent_next = 1'b1;
        res_status     = ST_ARB_LOST;
        res_done       = 1'b1;
      end else if (bit_position >= crc_start + FRAME_TAIL) begin
        // after the last EOF bit
        phase_next     = PH_IDLE;
        last_sent_next = 1'b1;
        res_status     = ack_flag_next ? ST_DONE_ACK : ST_DONE_NOACK;
        res_done       = 1'b1;
      end else if (stuff_pending) begin
        // stuff bit: complement, and it opens the next run
        res_tx             = !last_bit;
        last_bit_next      = !last_bit;
        run_length_next    = 3'd1;
        stuff_pending_next = 1'b0;
        last_sent_next     = !last_bit;
        res_status         = ST_SENDING;
      end else begin
        res_tx = fbit;
        if (in_stuff_zone) begin
          if (run_length != 3'd0 && fbit == last_bit) begin
            run_length_next = run_length + 3'd1;
          end else begin
            run_length_next = 3'd1;
          end
          last_bit_next = fbit;
          if (run_length_next >= STUFF_RUN) begin
            stuff_pending_next = 1'b1;
          end
        end
        if (in_crc_feed) begin
          crc_register_next = crc_shift;
        end
        bit_position_next = bit_position + 7'd1;
        last_sent_next    = fbit;
        res_status        = ST_SENDING;
      end
    end
  end

  // frame state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_position  <= 7'd0;
      id_store      <= 11'd0;
      length_store  <= 4'd0;
      payload_store <= 64'd0;
      crc_register  <= 15'd0;
      run_length    <= 3'd0;
      last_bit      <= 1'b0;
      stuff_pending <= 1'b0;
      last_sent     <= 1'b1;
      ack_flag      <= 1'b0;
      out_valid     <= 1'b0;
      tx_level      <= 1'b1;
      status        <= ST_IDLE;
      frame_done    <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        bit_position  <= bit_position_next;
        id_store      <= id_store_next;
        length_store  <= length_store_next;
        payload_store <= payload_store_next;
        crc_register  <= crc_register_next;
        run_length    <= run_length_next;
        last_bit      <= last_bit_next;
        stuff_pending <= stuff_pending_next;
        last_sent     <= last_sent_next;
        ack_flag      <= ack_flag_next;
        out_valid     <= 1'b1;
        tx_level      <= res_tx;
        status        <= res_status;
        frame_done    <= res_done;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
